@@ design/xdwm_pkg.sv @@
// Shared constants and types for the X-drive wheel mixer.
// Used by every module of the block; depends on nothing.

package xdwm_pkg;

  localparam int FRACTION_BITS = 8;
  localparam int IN_W          = 8;
  localparam int OUT_W         = 16;
  localparam int NUM_WHEELS    = 4;
  localparam int IN_TDATA_W    = 3 * IN_W;
  localparam int OUT_TDATA_W   = NUM_WHEELS * OUT_W;

  localparam int WHEEL_FL = 0;
  localparam int WHEEL_BL = 1;
  localparam int WHEEL_FR = 2;
  localparam int WHEEL_BR = 3;

  // Back wheels are mounted reversed, so their results are negated.
  localparam logic [NUM_WHEELS-1:0] WHEEL_REVERSED = 4'b1010;

  localparam int MAG_W      = IN_W;
  localparam int DEN_W      = IN_W + 1;
  localparam int N_W        = 2 * IN_W + 2;
  localparam int NMAG_W     = N_W - 1;
  localparam int PEAK_W     = NMAG_W;
  localparam int REM_W      = PEAK_W + 1;
  localparam int FULL_SCALE = 100;
  localparam int SCALE      = FULL_SCALE << FRACTION_BITS;
  localparam int Q_W        = $clog2(SCALE + 1);
  localparam int DIVD_W     = NMAG_W + Q_W;
  localparam int RES_W      = (Q_W + 1 > OUT_W) ? Q_W + 1 : OUT_W;

  localparam int MIX_STAGES = 3;
  localparam int PIPE_DEPTH = MIX_STAGES + Q_W + 2;

  typedef struct packed {
    logic [NMAG_W-1:0] mag;
    logic              neg;
  } lane_t;

  typedef struct packed {
    lane_t [NUM_WHEELS-1:0] lane;
    logic  [PEAK_W-1:0]     peak;
  } mix_t;

endpackage

@@ design/xdwm_mix.sv @@
// Front end of the wheel mixer: stick magnitudes, exact wheel numerators and the common peak.
// Three register stages; depends on xdwm_pkg.

module xdwm_mix
  import xdwm_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   vld_i,
  input  logic signed [IN_W-1:0] forward_i,
  input  logic signed [IN_W-1:0] strafe_i,
  input  logic signed [IN_W-1:0] rotate_i,
  output mix_t                   mix_o
);

  logic        [MAG_W-1:0] af, as, mx;
  logic        [DEN_W-1:0] sum, den;
  logic signed [IN_W-1:0]  f1_q, s1_q, r1_q;
  logic        [MAG_W-1:0] mx1_q;
  logic        [DEN_W-1:0] den1_q;

  always_comb begin
    af  = forward_i[IN_W-1] ? MAG_W'(-forward_i) : MAG_W'(forward_i);
    as  = strafe_i[IN_W-1] ? MAG_W'(-strafe_i) : MAG_W'(strafe_i);
    sum = DEN_W'(af) + DEN_W'(as);
    mx  = (af > as) ? af : as;
    den = (sum == '0) ? DEN_W'(1) : sum;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f1_q   <= forward_i;
      s1_q   <= strafe_i;
      r1_q   <= rotate_i;
      mx1_q  <= mx;
      den1_q <= den;
    end
  end

  logic signed [N_W-1:0]    fe, se, re, mxe, dene, fps, fms, trans_p, trans_m, rot;
  logic signed [N_W-1:0]    n_d  [NUM_WHEELS];
  logic signed [N_W-1:0]    n2_q [NUM_WHEELS];
  logic        [PEAK_W-1:0] base2_q;

  always_comb begin
    fe      = N_W'(f1_q);
    se      = N_W'(s1_q);
    re      = N_W'(r1_q);
    mxe     = N_W'(mx1_q);
    dene    = N_W'(den1_q);
    fps     = fe + se;
    fms     = fe - se;
    trans_p = fps * mxe;
    trans_m = fms * mxe;
    rot     = re * dene;
    n_d[WHEEL_FL] = trans_p + rot;
    n_d[WHEEL_BL] = trans_m + rot;
    n_d[WHEEL_FR] = trans_m - rot;
    n_d[WHEEL_BR] = trans_p - rot;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n2_q    <= n_d;
      base2_q <= PEAK_W'(den1_q) * PEAK_W'(FULL_SCALE);
    end
  end

  mix_t mix_d, mix_q;

  always_comb begin
    mix_d.peak = base2_q;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      mix_d.lane[i].mag = n2_q[i][N_W-1] ? NMAG_W'(-n2_q[i]) : NMAG_W'(n2_q[i]);
      mix_d.lane[i].neg = n2_q[i][N_W-1] ^ WHEEL_REVERSED[i];
      if (mix_d.lane[i].mag > mix_d.peak) begin
        mix_d.peak = mix_d.lane[i].mag;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mix_q <= mix_d;
    end
  end

  assign mix_o = mix_q;

  a_peak_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_i |-> (mix_q.peak >= mix_q.lane[WHEEL_FL].mag) && (mix_q.peak >= mix_q.lane[WHEEL_BL].mag)
           && (mix_q.peak >= mix_q.lane[WHEEL_FR].mag) && (mix_q.peak >= mix_q.lane[WHEEL_BR].mag))
    else $error("Peak is below a wheel magnitude.");

  a_peak_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_i |-> mix_q.peak >= PEAK_W'(FULL_SCALE))
    else $error("Peak is below full scale.");

endmodule

@@ design/xdwm_div.sv @@
// One wheel lane: scale by full range, pipelined restoring division by the peak, sign.
// One quotient bit per stage; depends on xdwm_pkg.

module xdwm_div
  import xdwm_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    vld_i,
  input  lane_t                   lane_i,
  input  logic [PEAK_W-1:0]       peak_i,
  output logic signed [OUT_W-1:0] speed_o
);

  logic [DIVD_W-1:0] prod;
  logic [PEAK_W-1:0] rem_q  [Q_W];
  logic [Q_W-1:0]    low_q  [Q_W];
  logic [PEAK_W-1:0] peak_q [Q_W];
  logic [Q_W-1:0]    quo_q  [Q_W+1];
  logic              neg_q  [Q_W+1];

  assign prod = DIVD_W'(lane_i.mag) * DIVD_W'(SCALE);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= prod[DIVD_W-1:Q_W];
      low_q[0]  <= prod[Q_W-1:0];
      peak_q[0] <= peak_i;
      quo_q[0]  <= '0;
      neg_q[0]  <= lane_i.neg;
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic [REM_W-1:0] trial, diff;
    logic             fits;

    always_comb begin
      trial = {rem_q[k], low_q[k][Q_W-1]};
      fits  = trial >= REM_W'(peak_q[k]);
      diff  = fits ? trial - REM_W'(peak_q[k]) : trial;
    end

    if (k < Q_W - 1) begin : g_mid
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k+1]  <= diff[PEAK_W-1:0];
          low_q[k+1]  <= low_q[k] << 1;
          peak_q[k+1] <= peak_q[k];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[k+1] <= {quo_q[k][Q_W-2:0], fits};
        neg_q[k+1] <= neg_q[k];
      end
    end
  end

  logic signed [RES_W-1:0] q_ext, res;
  logic signed [OUT_W-1:0] speed_q;

  always_comb begin
    q_ext = RES_W'(quo_q[Q_W]);
    res   = neg_q[Q_W] ? -q_ext : q_ext;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      speed_q <= res[OUT_W-1:0];
    end
  end

  assign speed_o = speed_q;

  a_quo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_i |-> quo_q[Q_W] <= Q_W'(SCALE))
    else $error("Wheel quotient exceeds full scale.");

endmodule

@@ design/x_drive_wheel_mixer.sv @@
// Top level of the X-drive wheel mixer: stream ports, pipeline control, four wheel lanes.
// Depends on xdwm_pkg, xdwm_mix and xdwm_div.
//
// One transfer on the slave side carries forward, strafe and rotation stick values,
// signed percent. One transfer on the master side carries the four wheel speeds,
// signed percent with FRACTION_BITS fraction bits, back wheels negated.
// Every input transfer yields exactly one output transfer, in order.
// Three stages form the wheel numerators and their common peak, one stage scales, then one
// stage per quotient bit divides, and a last stage applies the sign. Throughput is one
// transfer per cycle unless the receiver stalls; the whole pipeline advances together.
// The pipeline advances whenever the output register is empty or being taken; when the
// receiver stalls with a result waiting, every stage holds and s_axis_tready_o is low.
// Reset clears all valid bits, so no output transfer is offered until new data arrives.

module x_drive_wheel_mixer
  import xdwm_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // forward_axis [7:0], strafe_axis [15:8], rotate_axis [23:16]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // front_left_speed [15:0], back_left_speed [31:16],
  // front_right_speed [47:32], back_right_speed [63:48]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  logic [PIPE_DEPTH-1:0] valid_q, valid_d;
  logic                  en;

  assign en = !valid_q[PIPE_DEPTH-1] || m_axis_tready_i;

  always_comb begin
    valid_d = en ? {valid_q[PIPE_DEPTH-2:0], s_axis_tvalid_i} : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  logic signed [IN_W-1:0] forward, strafe, rotate;
  mix_t                   mix;
  logic signed [OUT_W-1:0] speed [NUM_WHEELS];

  assign forward = $signed(s_axis_tdata_i[IN_W-1:0]);
  assign strafe  = $signed(s_axis_tdata_i[2*IN_W-1:IN_W]);
  assign rotate  = $signed(s_axis_tdata_i[3*IN_W-1:2*IN_W]);

  xdwm_mix u_mix (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .vld_i     (valid_q[MIX_STAGES-1]),
    .forward_i (forward),
    .strafe_i  (strafe),
    .rotate_i  (rotate),
    .mix_o     (mix)
  );

  for (genvar i = 0; i < NUM_WHEELS; i++) begin : g_lane
    xdwm_div u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .vld_i   (valid_q[MIX_STAGES+Q_W]),
      .lane_i  (mix.lane[i]),
      .peak_i  (mix.peak),
      .speed_o (speed[i])
    );
  end

  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      m_axis_tdata_o[i*OUT_W +: OUT_W] = speed[i];
    end
  end

  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = valid_q[PIPE_DEPTH-1];

endmodule

@@ dv/x_drive_wheel_mixer_tb.sv @@
// Self-checking testbench for the X-drive wheel mixer: streams stick transfers in,
// predicts the four wheel speeds in a scoreboard class and checks every output transfer.
// Depends on xdwm_pkg and x_drive_wheel_mixer.
`timescale 1ns / 1ps

module x_drive_wheel_mixer_tb;
  import xdwm_pkg::*;

  typedef logic signed [IN_W-1:0] stick_t;

  typedef struct {
    stick_t                 fwd;
    stick_t                 strafe;
    stick_t                 rot;
    logic [OUT_TDATA_W-1:0] speeds;
  } wheel_expect_t;

  class wheel_score;
    wheel_expect_t speed_q[$];
    int            mismatches;

    function automatic logic [OUT_TDATA_W-1:0] mix_wheels(stick_t f, stick_t s, stick_t r);
      longint                 fv, sv, rv, af, as, den, mx, peak;
      longint                 num[NUM_WHEELS];
      longint                 wheel;
      logic [OUT_TDATA_W-1:0] packed_speeds;
      fv = f;
      sv = s;
      rv = r;
      af = (fv < 0) ? -fv : fv;
      as = (sv < 0) ? -sv : sv;
      mx = (af > as) ? af : as;
      den = (af + as != 0) ? af + as : 1;
      num[WHEEL_FL] = (fv + sv) * mx + rv * den;
      num[WHEEL_BL] = (fv - sv) * mx + rv * den;
      num[WHEEL_FR] = (fv - sv) * mx - rv * den;
      num[WHEEL_BR] = (fv + sv) * mx - rv * den;
      peak = FULL_SCALE * den;
      for (int i = 0; i < NUM_WHEELS; i++) begin
        if (num[i] > peak) peak = num[i];
        if (-num[i] > peak) peak = -num[i];
      end
      for (int i = 0; i < NUM_WHEELS; i++) begin
        wheel = (num[i] * (longint'(FULL_SCALE) << FRACTION_BITS)) / peak;
        if (WHEEL_REVERSED[i]) wheel = -wheel;
        packed_speeds[i*OUT_W +: OUT_W] = wheel[OUT_W-1:0];
      end
      return packed_speeds;
    endfunction

    function void note_sticks(stick_t f, stick_t s, stick_t r);
      wheel_expect_t e;
      e.fwd = f;
      e.strafe = s;
      e.rot = r;
      e.speeds = mix_wheels(f, s, r);
      speed_q.push_back(e);
    endfunction

    function void check_speeds(logic [OUT_TDATA_W-1:0] got);
      wheel_expect_t  e;
      logic [OUT_W-1:0] exp_w, got_w;
      string          wheel_name[NUM_WHEELS] = '{"front left", "back left",
                                                 "front right", "back right"};
      if (speed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected output transfer %h at %0t", got, $realtime);
        return;
      end
      e = speed_q.pop_front();
      for (int i = 0; i < NUM_WHEELS; i++) begin
        exp_w = e.speeds[i*OUT_W +: OUT_W];
        got_w = got[i*OUT_W +: OUT_W];
        if (got_w !== exp_w) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch on %s speed for sticks (%0d, %0d, %0d): expected %0d, got %0d",
                     wheel_name[i], e.fwd, e.strafe, e.rot,
                     $signed(exp_w), $signed(got_w));
        end
      end
    endfunction

    function int pending();
      return speed_q.size();
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  // forward_axis [7:0], strafe_axis [15:8], rotate_axis [23:16]
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  // front_left_speed [15:0], back_left_speed [31:16],
  // front_right_speed [47:32], back_right_speed [63:48]
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;

  wheel_score sb = new();
  int         burst_left;

  x_drive_wheel_mixer uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #200000;
    $display("Verification failed");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_sticks(stick_t f, stick_t s, stick_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 12) : 0;
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {r, s, f};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_sticks(f, s, r);
    @(negedge clk_i);
  endtask

  function automatic stick_t pick_axis();
    case ($urandom_range(0, 9))
      0:       return stick_t'($urandom_range(0, 255));
      1: begin
        case ($urandom_range(0, 4))
          0:       return 8'sd100;
          1:       return -8'sd100;
          2:       return 8'sd127;
          3:       return -8'sd128;
          default: return 8'sd0;
        endcase
      end
      default: return stick_t'(int'($urandom_range(0, 200)) - 100);
    endcase
  endfunction

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_random(int count);
    stick_t f, s, r;
    for (int i = 0; i < count; i++) begin
      f = pick_axis();
      s = ($urandom_range(0, 9) == 0) ? 8'sd0 : pick_axis();
      if ($urandom_range(0, 15) == 0) f = 8'sd0;
      r = ($urandom_range(0, 7) == 0) ? 8'sd0 : pick_axis();
      send_sticks(f, s, r);
    end
  endtask

  // Receiver back-pressure: modes change every stretch of cycles, including full speed.
  initial begin
    int mode;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(20, 120)) begin
        @(negedge clk_i);
        case (mode)
          0:       m_axis_tready_i <= 1'b1;
          1:       m_axis_tready_i <= $urandom_range(0, 1);
          2:       m_axis_tready_i <= ($urandom_range(0, 7) != 0);
          default: m_axis_tready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_speeds(m_axis_tdata_o);
  end

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    burst_left      = 0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Centered sticks, single axes at their limits, diagonals, and out-of-range values.
    send_sticks(8'sd0, 8'sd0, 8'sd0);
    send_sticks(8'sd100, 8'sd0, 8'sd0);
    send_sticks(-8'sd100, 8'sd0, 8'sd0);
    send_sticks(8'sd0, 8'sd100, 8'sd0);
    send_sticks(8'sd0, -8'sd100, 8'sd0);
    send_sticks(8'sd0, 8'sd0, 8'sd100);
    send_sticks(8'sd0, 8'sd0, -8'sd100);
    send_sticks(8'sd100, 8'sd100, 8'sd100);
    send_sticks(-8'sd100, -8'sd100, -8'sd100);
    send_sticks(8'sd100, -8'sd100, 8'sd100);
    send_sticks(-8'sd100, 8'sd100, -8'sd100);
    send_sticks(8'sd127, 8'sd127, 8'sd127);
    send_sticks(-8'sd128, -8'sd128, -8'sd128);
    send_sticks(-8'sd128, 8'sd127, 8'sd0);
    send_sticks(8'sd127, -8'sd128, -8'sd128);
    send_sticks(8'sd0, 8'sd0, 8'sd127);
    send_sticks(8'sd0, 8'sd0, -8'sd128);
    send_sticks(8'sd50, 8'sd50, 8'sd0);
    send_sticks(8'sd1, 8'sd0, 8'sd0);
    send_sticks(8'sd0, 8'sd1, -8'sd1);
    send_sticks(8'sd1, 8'sd1, 8'sd1);
    send_sticks(-8'sd1, -8'sd1, -8'sd1);
    send_sticks(8'sd100, 8'sd100, 8'sd0);
    send_sticks(8'sd30, -8'sd70, 8'sd45);
    drain_results();

    send_random(270);
    drain_results();
    send_random(270);
    drain_results();

    repeat (PIPE_DEPTH + 10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
